@@ rtl/srtf_pkg.sv @@
// srtf_pkg: shared types and codes for the srtf tick scheduler
// command and result payload structs, opcodes, cell control struct
// no dependencies

package srtf_pkg;

  localparam int FIELD_W = 16;
  localparam int ID_W    = 7;

  localparam logic [ID_W-1:0] NONE_ID = {ID_W{1'b1}};

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] arrival_time;
    logic [FIELD_W-1:0] burst_time;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    running_id;
    logic [FIELD_W-1:0] tick_time;
    logic               new_segment;
    logic               finished;
    logic [FIELD_W-1:0] finish_time;
    logic [FIELD_W-1:0] turnaround;
    logic [FIELD_W-1:0] waiting;
    logic [FIELD_W-1:0] response;
    logic               all_done;
    logic               load_error;
  } res_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic clear;
    logic update;
  } cell_ctl_t;

endpackage

@@ rtl/srtf_tick_scheduler.sv @@
// srtf_tick_scheduler: top level of the tick-driven srtf scheduler
// builds the chain of srtf_cell entries and the sequencer; depends on srtf_pkg

// Preemptive shortest-remaining-time-first scheduler. A load command adds a
// task (arrival, burst) whose id is its 1-based load order; a load into a full
// table of MAX_TASKS entries is refused with load_error. A tick command picks,
// among arrived unfinished tasks, the one with the least remaining time (ties
// to the lower id), runs it one unit, advances time (saturating at
// 2^TIME_WIDTH-1) and reports the running id, a new-segment flag and, when the
// task ends, its finish, turnaround, waiting and response times. Clear empties
// the table and zeroes time. Each task lives in one cell of a chain; a tick
// sends the best candidate down the chain one cell per cycle. A tick goes
// through the scan, update, metric and result states before its result
// enters the result register; load, clear and unused opcodes go straight
// to the result state. One command is worked on at a time; a result waits in
// the output register until its transfer, and the next command is taken
// meanwhile.

module srtf_tick_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  srtf_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output srtf_pkg::res_t res
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int CAND_W = 1 + IDX_W + 4 * TIME_WIDTH + 1;
  localparam int ID_W   = srtf_pkg::ID_W;
  localparam int FW     = srtf_pkg::FIELD_W;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_METRIC = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  // same layout as the candidate inside each cell
  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      idx;
    logic [TIME_WIDTH-1:0] remaining;
    logic [TIME_WIDTH-1:0] arrival;
    logic [TIME_WIDTH-1:0] burst;
    logic                  started;
    logic [TIME_WIDTH-1:0] first_start;
  } cand_t;

  logic [2:0]            state;
  logic [IDX_W-1:0]      scan_cnt;
  logic [TIME_WIDTH-1:0] current_time;
  logic [CNT_W-1:0]      task_count;
  logic [CNT_W-1:0]      done_count;
  logic [ID_W-1:0]       last_running;
  srtf_pkg::res_t        pend;
  logic [TIME_WIDTH-1:0] tat;
  logic [TIME_WIDTH-1:0] tat_burst;

  logic                  cmd_xfer;
  logic                  table_full;
  logic                  load_ok;
  logic [TIME_WIDTH-1:0] load_arrival;
  logic [TIME_WIDTH-1:0] load_burst;
  logic [TIME_WIDTH-1:0] time_inc;
  logic [TIME_WIDTH-1:0] start_time;
  logic [ID_W-1:0]       run_id;
  logic                  win_finish;
  cand_t                 win;
  srtf_pkg::res_t        start_res;
  srtf_pkg::res_t        res_next;

  srtf_pkg::cell_ctl_t   ctl;
  logic [IDX_W-1:0]      sel_idx;
  logic [CAND_W-1:0]     chain [MAX_TASKS];

  assign cmd_ready    = (state == ST_IDLE);
  assign cmd_xfer     = cmd_valid && cmd_ready;
  assign table_full   = (task_count >= CNT_W'(MAX_TASKS));
  assign load_ok      = cmd_xfer && (cmd.opcode == srtf_pkg::OP_LOAD) && !table_full;
  assign load_arrival = TIME_WIDTH'(cmd.arrival_time);
  assign load_burst   = TIME_WIDTH'(cmd.burst_time);

  // winner leaves the last cell of the chain
  assign win        = cand_t'(chain[MAX_TASKS-1]);
  assign time_inc   = (current_time == TIME_MAX) ? current_time
                                                 : current_time + TIME_WIDTH'(1);
  assign start_time = win.started ? win.first_start : current_time;
  assign run_id     = win.found ? ID_W'(win.idx) + ID_W'(1) : '0;
  assign win_finish = win.found && (win.remaining == TIME_WIDTH'(1));

  always_comb begin
    ctl.load   = load_ok;
    ctl.clear  = cmd_xfer && (cmd.opcode == srtf_pkg::OP_CLEAR);
    ctl.update = (state == ST_UPDATE) && win.found;
    sel_idx    = ctl.update ? win.idx : task_count[IDX_W-1:0];
  end

  // chain of task cells, the best candidate moves one cell per cycle
  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    logic [CAND_W-1:0] cand_in;
    if (k == 0) begin : g_head
      assign cand_in = '0;
    end else begin : g_link
      assign cand_in = chain[k-1];
    end
    srtf_cell #(
      .TIME_WIDTH (TIME_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (k),
      .CAND_W     (CAND_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sel_idx    (sel_idx),
      .wr_arrival (load_arrival),
      .wr_burst   (load_burst),
      .now        (current_time),
      .cand_in    (cand_in),
      .cand_out   (chain[k])
    );
  end

  // sequencer and scheduler counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_cnt     <= '0;
      current_time <= '0;
      task_count   <= '0;
      done_count   <= '0;
      last_running <= srtf_pkg::NONE_ID;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_xfer) begin
            scan_cnt <= '0;
            if (cmd.opcode == srtf_pkg::OP_TICK) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_RESULT;
            end
            if (load_ok) begin
              task_count <= task_count + CNT_W'(1);
              if (load_burst == '0) begin
                // zero burst counts as done right away
                done_count <= done_count + CNT_W'(1);
              end
            end
            if (cmd.opcode == srtf_pkg::OP_CLEAR) begin
              current_time <= '0;
              task_count   <= '0;
              done_count   <= '0;
              last_running <= srtf_pkg::NONE_ID;
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + IDX_W'(1);
          if (scan_cnt == IDX_W'(MAX_TASKS - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          last_running <= run_id;
          current_time <= time_inc;
          if (win_finish) begin
            done_count <= done_count + CNT_W'(1);
          end
          state <= ST_METRIC;
        end
        ST_METRIC: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!res_valid || res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result fields known at command transfer
  always_comb begin
    start_res           = '0;
    start_res.tick_time = FW'(current_time);
    if (cmd.opcode == srtf_pkg::OP_LOAD) begin
      start_res.load_error = table_full;
      if (!table_full) begin
        start_res.running_id = ID_W'(task_count) + ID_W'(1);
      end
    end
    if (cmd.opcode == srtf_pkg::OP_CLEAR) begin
      start_res.tick_time = '0;
    end
  end

  // pending result built up over the command's cycles
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          pend <= start_res;
        end
      end
      ST_UPDATE: begin
        pend.running_id  <= run_id;
        pend.new_segment <= (run_id != last_running);
        pend.finished    <= win_finish;
        tat              <= time_inc - win.arrival;
        tat_burst        <= win.burst;
        if (win_finish) begin
          pend.finish_time <= FW'(time_inc);
          pend.turnaround  <= FW'(time_inc - win.arrival);
          pend.response    <= FW'(start_time - win.arrival);
        end
      end
      ST_METRIC: begin
        // waiting clamps at zero once time has saturated
        if (pend.finished && (tat >= tat_burst)) begin
          pend.waiting <= FW'(tat - tat_burst);
        end
      end
      ST_SCAN, ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // output register, parts the result transfer from the command side
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_RESULT && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    res_next          = pend;
    res_next.all_done = (done_count == task_count);
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!res_valid || res_ready)) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/srtf_cell.sv @@
// srtf_cell: one task entry of the scheduler table plus one stage of the
// minimum-remaining-time chain; depends on srtf_pkg

module srtf_cell #(
  parameter int TIME_WIDTH = 16,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0,
  parameter int CAND_W     = 1 + IDX_W + 4 * TIME_WIDTH + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srtf_pkg::cell_ctl_t   ctl,
  input  logic [IDX_W-1:0]      sel_idx,
  input  logic [TIME_WIDTH-1:0] wr_arrival,
  input  logic [TIME_WIDTH-1:0] wr_burst,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [CAND_W-1:0]     cand_in,
  output logic [CAND_W-1:0]     cand_out
);

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      idx;
    logic [TIME_WIDTH-1:0] remaining;
    logic [TIME_WIDTH-1:0] arrival;
    logic [TIME_WIDTH-1:0] burst;
    logic                  started;
    logic [TIME_WIDTH-1:0] first_start;
  } cand_t;

  logic                  valid;
  logic [TIME_WIDTH-1:0] arrival;
  logic [TIME_WIDTH-1:0] burst;
  logic [TIME_WIDTH-1:0] remaining;
  logic                  started;
  logic [TIME_WIDTH-1:0] first_start;

  logic  hit;
  logic  eligible;
  logic  take;
  cand_t prev;
  cand_t own;
  cand_t cand_next;

  assign hit = (sel_idx == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.load && hit) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && hit) begin
      arrival     <= wr_arrival;
      burst       <= wr_burst;
      remaining   <= wr_burst;
      started     <= 1'b0;
      first_start <= '0;
    end else if (ctl.update && hit) begin
      remaining <= remaining - TIME_WIDTH'(1);
      if (!started) begin
        started     <= 1'b1;
        first_start <= now;
      end
    end
  end

  // strict compare keeps the earlier (lower id) entry on a tie
  always_comb begin
    prev      = cand_t'(cand_in);
    own.found       = 1'b1;
    own.idx         = IDX_W'(INDEX);
    own.remaining   = remaining;
    own.arrival     = arrival;
    own.burst       = burst;
    own.started     = started;
    own.first_start = first_start;
    eligible  = valid && (arrival <= now) && (remaining != '0);
    take      = eligible && (!prev.found || (remaining < prev.remaining));
    cand_next = take ? own : prev;
  end

  always_ff @(posedge clk) begin
    cand_out <= CAND_W'(cand_next);
  end

endmodule
